### hdl/tahc_pkg.sv
// shared types, constants and helpers for the threshold alarm qualifier
package tahc_pkg;

    localparam int NUM_CH        = 5;
    localparam int CH_W          = 3;
    localparam int RD_W          = 16;
    localparam int V_W           = 18;
    localparam int HOLD_W        = 26;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 16;
    localparam int TIME_BITS_DEF = 48;

    localparam logic [CH_W-1:0] CH_KNOCK   = 3'd0;
    localparam logic [CH_W-1:0] CH_BOOST   = 3'd1;
    localparam logic [CH_W-1:0] CH_COOLANT = 3'd2;
    localparam logic [CH_W-1:0] CH_OIL     = 3'd3;
    localparam logic [CH_W-1:0] CH_LAMP    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOCK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLANT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OIL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd5;

    localparam logic signed [RD_W-1:0] RST_KNOCK   = 16'sd64;
    localparam logic signed [RD_W-1:0] RST_BOOST   = 16'sd320;
    localparam logic signed [RD_W-1:0] RST_COOLANT = 16'sd3680;
    localparam logic signed [RD_W-1:0] RST_OIL     = 16'sd4160;
    localparam logic [HOLD_W-1:0]      RST_HOLD_US = 26'd10000000;
    localparam logic [9:0]             US_PER_MS   = 10'd1000;

    // celsius to fahrenheit: floor(x*9/5)+512 through a bias that keeps x positive
    localparam logic [19:0]          C2F_OFFSET = 20'd327680;
    localparam logic [20:0]          DIV5_MUL   = 21'd1677722;
    localparam logic signed [V_W-1:0] F_ADJ     = 18'sd65024;

    typedef struct packed {
        logic                   en;
        logic signed [RD_W-1:0] knock;
        logic signed [RD_W-1:0] boost;
        logic signed [RD_W-1:0] coolant;
        logic signed [RD_W-1:0] oil;
    } t_thr_cfg;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            go;
        logic            active;
        logic            clear;
    } t_eval;

    function automatic logic signed [V_W-1:0] hyst(input logic [CH_W-1:0] ch);
        logic signed [V_W-1:0] h;
        case (ch)
            CH_KNOCK:   h = 18'sd16;
            CH_BOOST:   h = 18'sd32;
            CH_COOLANT: h = 18'sd128;
            CH_OIL:     h = 18'sd128;
            default:    h = 18'sd0;
        endcase
        return h;
    endfunction

endpackage

### hdl/tahc_front.sv
// input register, unit conversion and threshold compare stages
module tahc_front
    import tahc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_thr_cfg               i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CH_W-1:0]        i_channel,
    input  logic signed [RD_W-1:0] i_reading,
    input  logic                   i_reading_valid,
    input  logic [TIME_BITS-1:0]   i_time_us,
    output logic                   o_ev_valid,
    input  logic                   i_ev_take,
    output t_eval                  o_ev,
    output logic [TIME_BITS-1:0]   o_ev_time
);

    logic                   r_s1_v;
    logic [CH_W-1:0]        r_s1_ch;
    logic signed [RD_W-1:0] r_s1_rd;
    logic                   r_s1_rv;
    logic [TIME_BITS-1:0]   r_s1_time;

    logic                   r_s2_v;
    logic [CH_W-1:0]        r_s2_ch;
    logic                   r_s2_go;
    logic signed [V_W-1:0]  r_s2_val;
    logic [TIME_BITS-1:0]   r_s2_time;

    logic                   r_s3_v;
    t_eval                  r_s3_ev;
    logic [TIME_BITS-1:0]   r_s3_time;

    logic mv23, mv12, s1_free, acc;

    // stage advance: a stage moves when the next one is empty or moving
    assign mv23    = r_s2_v && (!r_s3_v || i_ev_take);
    assign mv12    = r_s1_v && (!r_s2_v || mv23);
    assign s1_free = !r_s1_v || mv12;
    assign acc     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // stage 1 -> 2: eligibility and fahrenheit conversion
    logic signed [19:0]    rd_ext, x9;
    logic [19:0]           xo;
    logic [40:0]           prod;
    logic [V_W-1:0]        q;
    logic signed [V_W-1:0] f_val, n_s2_val;
    logic                  is_temp, n_s2_go;

    always_comb begin
        rd_ext  = {{4{r_s1_rd[RD_W-1]}}, r_s1_rd};
        x9      = (rd_ext <<< 3) + rd_ext;
        xo      = unsigned'(x9) + C2F_OFFSET;
        prod    = {21'b0, xo} * {20'b0, DIV5_MUL};
        q       = prod[40:23];
        f_val   = signed'(q) - F_ADJ;
        is_temp = (r_s1_ch == CH_COOLANT) || (r_s1_ch == CH_OIL);
        n_s2_val = is_temp ? f_val : {{(V_W-RD_W){r_s1_rd[RD_W-1]}}, r_s1_rd};
        // zero oil reading means no sensor report
        n_s2_go = i_cfg.en && r_s1_rv && (r_s1_ch < CH_W'(NUM_CH))
                  && !((r_s1_ch == CH_OIL) && (r_s1_rd == '0));
    end

    // stage 2 -> 3: threshold and re-arm compare
    logic signed [RD_W-1:0] thr;
    logic signed [V_W-1:0]  thr_ext, rearm_lim;
    t_eval                  n_s3_ev;

    always_comb begin
        case (r_s2_ch)
            CH_KNOCK:   thr = i_cfg.knock;
            CH_BOOST:   thr = i_cfg.boost;
            CH_COOLANT: thr = i_cfg.coolant;
            CH_OIL:     thr = i_cfg.oil;
            default:    thr = '0;
        endcase
        thr_ext   = {{(V_W-RD_W){thr[RD_W-1]}}, thr};
        rearm_lim = thr_ext - hyst(r_s2_ch);
        n_s3_ev.ch = r_s2_ch;
        n_s3_ev.go = r_s2_go;
        if (r_s2_ch == CH_LAMP) begin
            n_s3_ev.active = r_s2_val[0];
            n_s3_ev.clear  = !r_s2_val[0];
        end else begin
            n_s3_ev.active = (r_s2_val >= thr_ext);
            n_s3_ev.clear  = (r_s2_val < rearm_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_v <= 1'b1;
            end else if (mv12) begin
                r_s1_v <= 1'b0;
            end
            if (mv12) begin
                r_s2_v <= 1'b1;
            end else if (mv23) begin
                r_s2_v <= 1'b0;
            end
            if (mv23) begin
                r_s3_v <= 1'b1;
            end else if (i_ev_take) begin
                r_s3_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ch   <= i_channel;
            r_s1_rd   <= i_reading;
            r_s1_rv   <= i_reading_valid;
            r_s1_time <= i_time_us;
        end
        if (mv12) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_go   <= n_s2_go;
            r_s2_val  <= n_s2_val;
            r_s2_time <= r_s1_time;
        end
        if (mv23) begin
            r_s3_ev   <= n_s3_ev;
            r_s3_time <= r_s2_time;
        end
    end

    assign o_ev_valid = r_s3_v;
    assign o_ev       = r_s3_ev;
    assign o_ev_time  = r_s3_time;

`ifndef SYNTH
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_v && r_s2_v && r_s3_v))
        else $error("input stalled with an empty stage");
`endif

endmodule

### hdl/tahc_chan.sv
// per-channel arm flags, last firing times and the result register
module tahc_chan
    import tahc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [HOLD_W-1:0]    i_holdoff_us,
    input  logic                 i_ev_valid,
    output logic                 o_ev_take,
    input  t_eval                i_ev,
    input  logic [TIME_BITS-1:0] i_ev_time,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_W-1:0]      o_fired_channel,
    output logic                 o_fire
);

    logic [NUM_CH-1:0]    r_armed;
    logic [TIME_BITS-1:0] r_last [NUM_CH];
    logic                 r_out_v;
    logic [CH_W-1:0]      r_out_ch;
    logic                 r_out_fire;

    logic                 take, armed_sel, n_fire;
    logic [TIME_BITS-1:0] elapsed, hold_ext;

    assign take      = i_ev_valid && (!r_out_v || !i_out_stall);
    assign o_ev_take = take;

    always_comb begin
        armed_sel = i_ev.go ? r_armed[i_ev.ch] : 1'b0;
        elapsed   = i_ev.go ? (i_ev_time - r_last[i_ev.ch]) : '0;
        hold_ext  = {{(TIME_BITS-HOLD_W){1'b0}}, i_holdoff_us};
        // a clear and an active reading never coincide, so re-arm needs no bypass
        n_fire    = i_ev.go && i_ev.active && armed_sel && (elapsed > hold_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '1;
            for (int i = 0; i < NUM_CH; i++) begin
                r_last[i] <= '0;
            end
        end else if (take && i_ev.go) begin
            if (i_ev.clear) begin
                r_armed[i_ev.ch] <= 1'b1;
            end
            if (n_fire) begin
                r_armed[i_ev.ch] <= 1'b0;
                r_last[i_ev.ch]  <= i_ev_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (take) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_ch   <= i_ev.ch;
            r_out_fire <= n_fire;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_fired_channel = r_out_ch;
    assign o_fire          = r_out_fire;

`ifndef SYNTH
    a_fire_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && n_fire) |=> (r_out_v && r_out_fire))
        else $error("firing lost on the way to the result register");
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && n_fire) |=> (r_armed[$past(i_ev.ch)] == 1'b0))
        else $error("channel still armed after firing");
    a_idle_keeps_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_armed))
        else $error("arm flags changed without a transfer");
`endif

endmodule

### hdl/threshold_alarm_hysteresis_cooldown_top.sv
// top level of the five-channel threshold alarm with hysteresis and holdoff
//
// usage: one sensor reading enters per transfer on the input channel
// (i_in_valid / o_in_stall) with its channel, reading, valid flag and
// microsecond timestamp. every transfer yields exactly one result on the
// output channel (o_out_valid / i_out_stall): the channel echoed and a fire
// flag. a new reading can be taken in every cycle unless o_in_stall is high;
// the result passes through the input register, conversion register,
// compare register, then the arm/holdoff update into the result register.
// throughput is one item per cycle while the output is not stalled, set by
// the arm flag and last-fire-time update per channel on each transfer.
// when the receiver stalls, the result register holds and the stages behind
// it keep filling; o_in_stall rises only once all four registers are full.
// reset (synchronous, active low) arms every channel, zeroes the last firing
// times, empties the pipeline and loads the default thresholds and holdoff.
// configuration writes through i_cfg_we / i_cfg_idx / i_cfg_data take effect
// at once and are meant for an idle block.
module threshold_alarm_hysteresis_cooldown_top
    import tahc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CH_W-1:0]        i_channel,
    input  logic signed [RD_W-1:0] i_reading,
    input  logic                   i_reading_valid,
    input  logic [TIME_BITS-1:0]   i_time_us,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [CH_W-1:0]        o_fired_channel,
    output logic                   o_fire
);

    t_thr_cfg             r_cfg;
    logic [HOLD_W-1:0]    r_holdoff_us;
    logic [HOLD_W-1:0]    n_holdoff_us;

    logic                 ev_valid, ev_take;
    t_eval                ev;
    logic [TIME_BITS-1:0] ev_time;

    // holdoff kept in microseconds so the compare needs no multiply
    assign n_holdoff_us = {10'b0, i_cfg_data} * {16'b0, US_PER_MS};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en      <= 1'b1;
            r_cfg.knock   <= RST_KNOCK;
            r_cfg.boost   <= RST_BOOST;
            r_cfg.coolant <= RST_COOLANT;
            r_cfg.oil     <= RST_OIL;
            r_holdoff_us  <= RST_HOLD_US;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_cfg.en      <= i_cfg_data[0];
                CFG_KNOCK:    r_cfg.knock   <= signed'(i_cfg_data);
                CFG_BOOST:    r_cfg.boost   <= signed'(i_cfg_data);
                CFG_COOLANT:  r_cfg.coolant <= signed'(i_cfg_data);
                CFG_OIL:      r_cfg.oil     <= signed'(i_cfg_data);
                CFG_COOLDOWN: r_holdoff_us  <= n_holdoff_us;
                default:      ;
            endcase
        end
    end

    tahc_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_channel       (i_channel),
        .i_reading       (i_reading),
        .i_reading_valid (i_reading_valid),
        .i_time_us       (i_time_us),
        .o_ev_valid      (ev_valid),
        .i_ev_take       (ev_take),
        .o_ev            (ev),
        .o_ev_time       (ev_time)
    );

    tahc_chan #(
        .TIME_BITS (TIME_BITS)
    ) u_chan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_holdoff_us    (r_holdoff_us),
        .i_ev_valid      (ev_valid),
        .o_ev_take       (ev_take),
        .i_ev            (ev),
        .i_ev_time       (ev_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fired_channel (o_fired_channel),
        .o_fire          (o_fire)
    );

endmodule

### tb/tb_threshold_alarm_hysteresis_cooldown_top.sv
// testbench for the five-channel threshold alarm: directed cases, random traffic, scoreboard
module tb_threshold_alarm_hysteresis_cooldown_top;
    import tahc_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            fire;
    } t_alarm_result;

    localparam longint HYST_16THS [0:3] = '{16, 32, 128, 128};

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_W-1:0]             i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [CH_W-1:0]              i_channel;
    logic signed [RD_W-1:0]       i_reading;
    logic                         i_reading_valid;
    logic [TIME_BITS_DEF-1:0]     i_time_us;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [CH_W-1:0]              o_fired_channel;
    logic                         o_fire;

    // predictor copy of the configuration and per-channel state
    logic                         alerts_on;
    logic signed [RD_W-1:0]       limit_cfg [0:3];
    logic [CFG_W-1:0]             cooldown_cfg;
    logic                         armed_q [0:NUM_CH-1];
    logic [TIME_BITS_DEF-1:0]     last_fire_q [0:NUM_CH-1];

    t_alarm_result                pending_alarms[$];
    int                           mismatch_count = 0;
    logic [TIME_BITS_DEF-1:0]     now_us = '0;
    bit                           tx_idle_on = 1'b1;
    bit                           rx_idle_on = 1'b1;
    int                           stall_left = 0;

    threshold_alarm_hysteresis_cooldown_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_channel       (i_channel),
        .i_reading       (i_reading),
        .i_reading_valid (i_reading_valid),
        .i_time_us       (i_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fired_channel (o_fired_channel),
        .o_fire          (o_fire)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // celsius to fahrenheit in 1/16 units, rounded toward minus infinity
    function automatic longint c_to_f(logic signed [RD_W-1:0] c);
        longint x;
        longint q;
        x = longint'(c) * 9;
        q = x / 5;
        if ((x % 5) != 0 && x < 0)
            q = q - 1;
        return q + 512;
    endfunction

    function automatic logic alarm_eval(logic [CH_W-1:0] ch, logic signed [RD_W-1:0] rd,
                                        logic vld, logic [TIME_BITS_DEF-1:0] stamp);
        longint                   v;
        longint                   thr;
        logic                     active;
        logic                     clear;
        logic [TIME_BITS_DEF-1:0] elapsed;
        if (!alerts_on || !vld || ch >= NUM_CH)
            return 1'b0;
        if (ch == CH_LAMP) begin
            active = rd[0];
            clear  = !rd[0];
        end else begin
            // an oil reading of zero means the sensor did not report
            if (ch == CH_OIL && rd == 0)
                return 1'b0;
            v = longint'(rd);
            if (ch == CH_COOLANT || ch == CH_OIL)
                v = c_to_f(rd);
            thr    = longint'(limit_cfg[ch]);
            active = (v >= thr);
            clear  = (v < thr - HYST_16THS[ch]);
        end
        if (clear)
            armed_q[ch] = 1'b1;
        if (active && armed_q[ch]) begin
            elapsed = stamp - last_fire_q[ch];
            if (longint'(elapsed) > longint'(cooldown_cfg) * 1000) begin
                armed_q[ch]     = 1'b0;
                last_fire_q[ch] = stamp;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_reading(logic [CH_W-1:0] ch, logic signed [RD_W-1:0] rd,
                                logic vld, logic [TIME_BITS_DEF-1:0] stamp);
        int            gap;
        t_alarm_result want;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_channel       <= ch;
        i_reading       <= rd;
        i_reading_valid <= vld;
        i_time_us       <= stamp;
        do
            @(posedge i_clk);
        while (o_in_stall);
        want.ch   = ch;
        want.fire = alarm_eval(ch, rd, vld, stamp);
        pending_alarms.push_back(want);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ENABLE:   alerts_on = val[0];
            CFG_KNOCK:    limit_cfg[CH_KNOCK] = val;
            CFG_BOOST:    limit_cfg[CH_BOOST] = val;
            CFG_COOLANT:  limit_cfg[CH_COOLANT] = val;
            CFG_OIL:      limit_cfg[CH_OIL] = val;
            CFG_COOLDOWN: cooldown_cfg = val;
            default: ;
        endcase
    endtask

    task automatic wait_results_done();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_alarms.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_alarms.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_alarms.size()));
            pending_alarms.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // timestamps mostly walk forward in steps scaled to the holdoff
    function automatic logic [TIME_BITS_DEF-1:0] advance_clock();
        logic [31:0]              hold;
        logic [TIME_BITS_DEF-1:0] step;
        hold = 32'(cooldown_cfg) * 32'd1000;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: step = 48'($urandom_range(0, hold / 4 + 2));
            4, 5:       step = 48'(hold + $urandom_range(0, 2));
            6, 7:       step = 48'($urandom_range(hold, 2 * hold + 10));
            8:          step = 48'({$urandom, $urandom});
            default:    step = '0;
        endcase
        now_us = now_us + step;
        return now_us;
    endfunction

    // reading close to the channel limit so both firing and re-arming happen
    function automatic logic signed [RD_W-1:0] near_reading(logic [CH_W-1:0] ch);
        longint centre;
        longint r;
        if (ch == CH_COOLANT || ch == CH_OIL) begin
            centre = ((longint'(limit_cfg[ch]) - 512) * 5) / 9;
            r = centre + longint'($urandom_range(0, 240)) - 120;
        end else begin
            centre = longint'(limit_cfg[ch]);
            r = centre + longint'($urandom_range(0, 400)) - 200;
        end
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    task automatic random_reading();
        logic [CH_W-1:0]          ch;
        logic signed [RD_W-1:0]   rd;
        logic                     vld;
        logic [TIME_BITS_DEF-1:0] stamp;
        if ($urandom_range(0, 6) == 0) begin
            ch    = CH_W'($urandom_range(0, 7));
            rd    = 16'($urandom);
            vld   = 1'($urandom_range(0, 1));
            stamp = 48'({$urandom, $urandom});
        end else begin
            ch    = CH_W'($urandom_range(0, NUM_CH - 1));
            vld   = ($urandom_range(0, 19) != 0);
            stamp = advance_clock();
            if (ch == CH_LAMP)
                rd = 16'($urandom);
            else
                rd = near_reading(ch);
        end
        send_reading(ch, rd, vld, stamp);
    endtask

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    task automatic randomize_registers();
        logic [CFG_W-1:0] hold_ms;
        case ($urandom_range(0, 4))
            0:       hold_ms = '0;
            1:       hold_ms = 16'hffff;
            2:       hold_ms = 16'($urandom_range(1, 20));
            default: hold_ms = 16'($urandom);
        endcase
        write_reg(CFG_ENABLE, ($urandom_range(0, 5) != 0) ? 16'd1 : 16'd0);
        write_reg(CFG_KNOCK, pick_limit());
        write_reg(CFG_BOOST, pick_limit());
        write_reg(CFG_COOLANT, pick_limit());
        write_reg(CFG_OIL, pick_limit());
        write_reg(CFG_COOLDOWN, hold_ms);
    endtask

    // reset values: first firing, holdoff edge, hysteresis, wrap, every channel
    task automatic test_defaults_and_holdoff();
        send_reading(CH_KNOCK, 16'sd64, 1'b1, 48'd0);
        send_reading(CH_KNOCK, 16'sd64, 1'b1, 48'd10_000_000);
        send_reading(CH_KNOCK, 16'sd64, 1'b1, 48'd10_000_001);
        send_reading(CH_KNOCK, 16'sd32767, 1'b1, 48'hffff_ffff_fffb);
        send_reading(CH_KNOCK, 16'sd48, 1'b1, 48'hffff_ffff_fffb);
        send_reading(CH_KNOCK, 16'sd47, 1'b1, 48'hffff_ffff_fffb);
        send_reading(CH_KNOCK, 16'sd64, 1'b1, 48'hffff_ffff_fffb);
        send_reading(CH_KNOCK, -16'sd32768, 1'b1, 48'd0);
        // elapsed time wraps past the top of the timestamp range
        send_reading(CH_KNOCK, 16'sd64, 1'b1, 48'd9_999_999);
        send_reading(CH_BOOST, 16'sd32767, 1'b0, 48'd50_000_000);
        send_reading(CH_BOOST, 16'sd320, 1'b1, 48'd50_000_000);
        send_reading(CH_COOLANT, 16'sd1760, 1'b1, 48'd50_000_000);
        send_reading(CH_COOLANT, 16'sd1759, 1'b1, 48'd50_000_000);
        send_reading(CH_COOLANT, -16'sd1, 1'b1, 48'd50_000_000);
        send_reading(CH_COOLANT, -16'sd32768, 1'b1, 48'd70_000_000);
        send_reading(CH_OIL, 16'sd0, 1'b1, 48'd60_000_000);
        send_reading(CH_OIL, 16'sd32767, 1'b1, 48'd60_000_000);
        send_reading(CH_LAMP, 16'sd1, 1'b1, 48'd60_000_000);
        send_reading(CH_LAMP, -16'sd1, 1'b1, 48'd80_000_000);
        send_reading(CH_LAMP, 16'sh7ffe, 1'b1, 48'd80_000_000);
        send_reading(CH_LAMP, -16'sd1, 1'b1, 48'd80_000_000);
        send_reading(3'd5, 16'sd32767, 1'b1, 48'hffff_ffff_ffff);
        send_reading(3'd6, -16'sd32768, 1'b1, 48'hffff_ffff_ffff);
        send_reading(3'd7, 16'sd1, 1'b1, 48'hffff_ffff_ffff);
    endtask

    task automatic test_register_extremes();
        wait_results_done();
        write_reg(CFG_ENABLE, 16'd0);
        send_reading(CH_KNOCK, 16'sd32767, 1'b1, 48'h8000_0000_0000);
        send_reading(CH_LAMP, 16'sd1, 1'b1, 48'h8000_0000_0000);
        wait_results_done();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_KNOCK, 16'h8000);
        write_reg(CFG_BOOST, 16'h8000);
        write_reg(CFG_COOLANT, 16'h8000);
        write_reg(CFG_OIL, 16'h8000);
        write_reg(CFG_COOLDOWN, 16'h0000);
        send_reading(CH_OIL, 16'sd0, 1'b1, 48'd1);
        send_reading(CH_OIL, 16'sd1, 1'b1, 48'd1);
        send_reading(CH_KNOCK, -16'sd32768, 1'b1, 48'd0);
        send_reading(CH_KNOCK, -16'sd32768, 1'b1, 48'd1);
        send_reading(CH_BOOST, -16'sd32768, 1'b1, 48'd1);
        send_reading(CH_COOLANT, -16'sd32768, 1'b1, 48'd1);
        wait_results_done();
        write_reg(CFG_KNOCK, 16'h7fff);
        write_reg(CFG_BOOST, 16'h7fff);
        write_reg(CFG_COOLANT, 16'h7fff);
        write_reg(CFG_OIL, 16'h7fff);
        write_reg(CFG_COOLDOWN, 16'hffff);
        send_reading(CH_KNOCK, 16'sd32767, 1'b1, 48'd65_535_000);
        send_reading(CH_KNOCK, 16'sd32767, 1'b1, 48'd65_535_001);
        send_reading(CH_BOOST, 16'sd32766, 1'b1, 48'hffff_ffff_ffff);
        send_reading(CH_COOLANT, 16'sd32767, 1'b1, 48'hffff_ffff_ffff);
        send_reading(CH_OIL, -16'sd32768, 1'b1, 48'hffff_ffff_ffff);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            wait_results_done();
            randomize_registers();
            repeat (140) random_reading();
        end
    endtask

    task automatic test_back_to_back();
        wait_results_done();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_KNOCK, 16'd64);
        write_reg(CFG_BOOST, 16'd320);
        write_reg(CFG_COOLANT, 16'd3680);
        write_reg(CFG_OIL, 16'd4160);
        write_reg(CFG_COOLDOWN, 16'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (170) random_reading();
    endtask

    // receiver stalls in bursts of random length
    always @(negedge i_clk) begin
        if (!rx_idle_on)
            i_out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (i_out_stall)
            i_out_stall <= 1'b0;
        else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 14);
        end
    end

    always @(posedge i_clk) begin
        t_alarm_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_alarms.size() == 0) begin
                flag_mismatch($sformatf("unexpected result ch %0d fire %0b",
                                        o_fired_channel, o_fire));
            end else begin
                want = pending_alarms.pop_front();
                if (o_fired_channel !== want.ch)
                    flag_mismatch($sformatf("channel %0d, want %0d", o_fired_channel, want.ch));
                if (o_fire !== want.fire)
                    flag_mismatch($sformatf("ch %0d fire %0b, want %0b",
                                            want.ch, o_fire, want.fire));
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_channel       = '0;
        i_reading       = '0;
        i_reading_valid = 1'b0;
        i_time_us       = '0;
        i_out_stall     = 1'b0;
        alerts_on       = 1'b1;
        limit_cfg[CH_KNOCK]   = RST_KNOCK;
        limit_cfg[CH_BOOST]   = RST_BOOST;
        limit_cfg[CH_COOLANT] = RST_COOLANT;
        limit_cfg[CH_OIL]     = RST_OIL;
        cooldown_cfg    = 16'd10000;
        for (int c = 0; c < NUM_CH; c++) begin
            armed_q[c]     = 1'b1;
            last_fire_q[c] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_and_holdoff();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();

        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_threshold_alarm_hysteresis_cooldown_top: clean");
        else
            $display("tb_threshold_alarm_hysteresis_cooldown_top: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_threshold_alarm_hysteresis_cooldown_top: errors");
        $finish;
    end

endmodule

### filelist.f
hdl/tahc_pkg.sv
hdl/tahc_front.sv
hdl/tahc_chan.sv
hdl/threshold_alarm_hysteresis_cooldown_top.sv
tb/tb_threshold_alarm_hysteresis_cooldown_top.sv
